### hdl/plset_pkg.sv
// package: constants, tables and types for the event thinning block
`timescale 1ns / 1ps
`default_nettype none
package plset_pkg;

  localparam int TableIndexBits = 8;
  localparam int LogW = 40;

  localparam logic [47:0] LcgMul = 48'h0005DEECE66D;
  localparam logic [47:0] LcgAdd = 48'h00000000000B;
  localparam logic [47:0] LcgReset = 48'h1234ABCD330E;
  localparam logic [15:0] SeedLow = 16'h330E;
  localparam logic [31:0] GainReset = 32'd65536;
  localparam logic [31:0] BreakQ22 = 32'd23586304;
  localparam logic signed [LogW-1:0] Log2E0Neg = 40'sd2786635;
  localparam logic signed [LogW-1:0] Log2Norm1 = 40'sd19617912;
  localparam logic [17:0] ExpLow = 18'd81920;
  localparam logic [17:0] ExpHigh = 18'd53084;

  localparam logic [1:0] CfgGain = 2'd0;
  localparam logic [1:0] CfgSeed = 2'd1;

  function automatic logic [31:0] pow_frac(input logic [3:0] k);
    logic [31:0] r;
    case (k)
      4'd0: r = 32'd3037000500;
      4'd1: r = 32'd2553802834;
      4'd2: r = 32'd2341847524;
      4'd3: r = 32'd2242560866;
      4'd4: r = 32'd2194507417;
      4'd5: r = 32'd2170868212;
      4'd6: r = 32'd2159144272;
      4'd7: r = 32'd2153306067;
      4'd8: r = 32'd2150392886;
      4'd9: r = 32'd2148937775;
      4'd10: r = 32'd2148210589;
      4'd11: r = 32'd2147847088;
      default: r = 32'd2147483648;
    endcase
    return r;
  endfunction

  // front to back queue word
  typedef struct packed {
    logic [31:0] energy;
    logic [31:0] gain;
    logic        high;
    logic [47:0] draw;
  } job_t;

endpackage
`default_nettype wire

### hdl/plset_if.sv
// valid/ready channel interface
`timescale 1ns / 1ps
`default_nettype none
interface plset_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### hdl/plset_front.sv
// front: takes energies, advances the generator, classifies the segment
`timescale 1ns / 1ps
`default_nettype none
module plset_front
  import plset_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] in_energy,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [31:0] cfg_data,
  output logic             q_valid,
  input  wire logic        q_ready,
  output job_t             q_job
);
  logic [47:0] state_r, state_nxt;
  logic [31:0] gain_r;
  logic        full_r;
  job_t        job_r;
  logic [31:0] v;
  logic [63:0] lcg_lo;
  logic [15:0] lcg_ha, lcg_hb;

  assign in_ready = !full_r || q_ready;
  assign q_valid = full_r;
  assign q_job = job_r;
  assign v = (in_energy == 32'd0) ? 32'd1 : in_energy;
  // product mod 2^48 split so no multiplier is wider than 32 by 32
  assign lcg_lo = state_r[31:0] * LcgMul[31:0];
  assign lcg_ha = 16'(state_r[47:32] * LcgMul[15:0]);
  assign lcg_hb = 16'(state_r[15:0] * LcgMul[47:32]);
  assign state_nxt = lcg_lo[47:0] + {lcg_ha + lcg_hb, 32'd0} + LcgAdd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LcgReset;
      gain_r <= GainReset;
      full_r <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == CfgGain) gain_r <= cfg_data;
      if (cfg_we && cfg_idx == CfgSeed) state_r <= {cfg_data, SeedLow};
      if (in_valid && in_ready) begin
        state_r <= state_nxt;
        full_r <= 1'b1;
      end else if (q_ready) begin
        full_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      job_r.energy <= v;
      job_r.gain <= gain_r;
      job_r.high <= (v > BreakQ22);
      job_r.draw <= state_nxt;
    end
  end
endmodule
`default_nettype wire

### hdl/plset_back.sv
// back: log2 by iterated squaring, exponent scaling and exp2 by table products
`timescale 1ns / 1ps
`default_nettype none
module plset_back
  import plset_pkg::*;
#(
  parameter int TABLE_INDEX_BITS = TableIndexBits
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  job_t             q_job,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accept,
  output logic [31:0]      out_prob,
  output logic [47:0]      out_draw
);
  localparam int B = TABLE_INDEX_BITS;
  localparam int CW = $clog2(B + 2);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_LOGE = 7'b0000010, S_LOGG = 7'b0000100,
    S_SCALE = 7'b0001000, S_EXPS = 7'b0010000, S_EXP = 7'b0100000,
    S_DONE = 7'b1000000
  } st_t;

  st_t state_r, state_nxt;
  job_t job_r;
  logic [CW-1:0] cnt_r;
  logic [32:0] y_r;
  logic [B-1:0] fr_r;
  logic [4:0] p_r;
  logic signed [LogW-1:0] lx_r, lw_r;
  logic signed [LogW+18:0] prod_r;
  logic [31:0] mant_r;
  logic [4:0] ip_r;
  logic [B-1:0] fb_r;
  logic [31:0] w_r;
  logic out_full_r;

  logic [31:0] src;
  logic [4:0] lead;
  logic [31:0] norm;
  logic [65:0] sq;
  logic [32:0] sq31;
  logic signed [LogW-1:0] lg;
  logic signed [LogW-1:0] e_val;
  logic [63:0] mprod;
  logic signed [LogW+18:0] fl;

  assign src = state_r == S_LOGE ? job_r.energy : job_r.gain;

  always_comb begin
    lead = 5'd0;
    for (int i = 0; i < 32; i++) if (src[i]) lead = 5'(i);
  end
  assign norm = src << (5'd31 - lead);
  assign sq = y_r * y_r;
  assign sq31 = 33'(sq >> 31);
  assign lg = (LogW'(p_r) <<< 24) + (LogW'(fr_r) <<< (24 - B));
  assign fl = prod_r >>> 16;
  assign e_val = lw_r + (LogW'(28) <<< 24);
  assign mprod = mant_r * pow_frac(4'(cnt_r - 1'b1));

  assign q_ready = state_r == S_IDLE;
  assign out_valid = out_full_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (q_valid) state_nxt = (q_job.gain == 32'd0) ? S_DONE : S_LOGE;
      S_LOGE: if (cnt_r == CW'(B + 1)) state_nxt = S_LOGG;
      S_LOGG: if (cnt_r == CW'(B + 1)) state_nxt = S_SCALE;
      S_SCALE: state_nxt = S_EXPS;
      S_EXPS: state_nxt = S_EXP;
      S_EXP: if (cnt_r == CW'(B)) state_nxt = S_DONE;
      S_DONE: if (!out_full_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_full_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_DONE && state_nxt == S_IDLE) out_full_r <= 1'b1;
      else if (out_ready) out_full_r <= 1'b0;
      if (state_r != state_nxt) cnt_r <= '0;
      else cnt_r <= cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        job_r <= q_job;
        w_r <= 32'd0;
      end
      S_LOGE, S_LOGG: begin
        if (cnt_r == '0) begin
          y_r <= {1'b0, norm};
          p_r <= lead;
          fr_r <= '0;
        end
        if (cnt_r != '0 && cnt_r != CW'(B)) begin
          // one fraction bit per squaring
        end
        if (cnt_r == CW'(B + 1)) begin
          if (state_r == S_LOGE) lx_r <= lg - (LogW'(22) <<< 24) + Log2E0Neg;
          else lw_r <= lg - (LogW'(16) <<< 24);
        end
      end
      S_SCALE: prod_r <= lx_r * $signed({1'b0, job_r.high ? ExpHigh : ExpLow});
      S_EXPS: begin
        lw_r <= lw_r - LogW'(fl) - (job_r.high ? Log2Norm1 : '0);
      end
      S_EXP: begin
        if (cnt_r == '0) begin
          mant_r <= 32'h80000000;
          ip_r <= 5'(e_val >>> 24);
          fb_r <= B'(e_val[23:0] >> (24 - B));
        end else if (fb_r[B - 32'(cnt_r)]) begin
          mant_r <= 32'(mprod >> 31);
        end
        if (cnt_r == CW'(B)) begin
          if (e_val < 0) w_r <= 32'd0;
          else if (e_val >= (LogW'(32) <<< 24)) w_r <= 32'hFFFFFFFF;
        end
      end
      S_DONE: begin
        if (state_nxt == S_IDLE) begin
          out_prob <= w_r;
          out_draw <= job_r.draw;
          out_accept <= {4'd0, job_r.draw} < {w_r, 20'd0};
        end
      end
      default: ;
    endcase
    if ((state_r == S_LOGE || state_r == S_LOGG) && cnt_r != '0
        && cnt_r <= CW'(B)) begin
      if (sq31[32]) begin
        y_r <= sq31 >> 1;
        fr_r <= {fr_r[B-2:0], 1'b1};
      end else begin
        y_r <= sq31;
        fr_r <= {fr_r[B-2:0], 1'b0};
      end
    end
    if (state_r == S_EXP && cnt_r == CW'(B) && !(e_val < 0)
        && !(e_val >= (LogW'(32) <<< 24))) begin
      w_r <= (fb_r[0] ? 32'(mprod >> 31) : mant_r) >> (5'd31 - ip_r);
    end
  end
endmodule
`default_nettype wire

### hdl/power_law_spectrum_event_thinning.sv
// top level: broken power-law event thinning
// the back end takes a new word only when idle and finishes each before the next;
// a zero gain skips the log2, scaling and exp2 steps; the front queues one word
// reset: generator state 0x1234ABCD330E, gain 1.0, channels empty
`timescale 1ns / 1ps
`default_nettype none
module power_law_spectrum_event_thinning
  import plset_pkg::*;
#(
  parameter int TABLE_INDEX_BITS = TableIndexBits
) (
  input wire logic clk,
  input wire logic rst_n,
  plset_if.sink    in_ch,
  plset_if.source  out_ch,
  plset_if.sink    cfg_ch
);
  logic q_valid, q_ready;
  job_t q_job;
  logic acc;
  logic [31:0] prob;
  logic [47:0] draw;

  assign cfg_ch.ready = 1'b1;

  plset_front u_front (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_energy(in_ch.data[31:0]),
    .cfg_we(cfg_ch.valid),
    .cfg_idx(cfg_ch.data[33:32]), .cfg_data(cfg_ch.data[31:0]),
    .q_valid, .q_ready, .q_job
  );

  plset_back #(.TABLE_INDEX_BITS(TABLE_INDEX_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_job,
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .out_accept(acc), .out_prob(prob), .out_draw(draw)
  );

  assign out_ch.data = {draw, prob, acc};
endmodule
`default_nettype wire
